FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define ASSERT_CLKD(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("property violated");

// Check a result-field rule on every rising edge outside reset
`define ASSERT_RESULT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("result fields inconsistent");

`endif

FILE: rtl/core/fdom_pkg.sv
// ----------------------------------------------------------------------------
// fdom_pkg
// Shared widths, codes and controller/datapath interface types for the
// drop-oldest FIFO with running mean.
// ----------------------------------------------------------------------------
package fdom_pkg;

	// Field widths
	localparam int TAG_W    = 16;
	localparam int HEIGHT_W = 12;
	localparam int MEAN_W   = 12;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 3;

	// Operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_INSERT      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INSERT_DROP = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REMOVE      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY       = 2'd3;

	// Divider: quotient bits, bits resolved per cycle, cycles per divide
	localparam int DIV_BITS     = MEAN_W;
	localparam int DIV_PER_CYC  = 3;
	localparam int DIV_CYCLES   = DIV_BITS / DIV_PER_CYC;
	localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;    // transfer in: update store, latch result, seed divider
		logic div_step;  // advance the divider by DIV_PER_CYC bits
		logic load_out;  // move the finished result into the output register
	} fdom_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic op_insert; // incoming item is an insert
		logic out_free;  // output register can take a result this cycle
	} fdom_stat_t;

endpackage

FILE: rtl/core/fdom_ctrl.sv
// ----------------------------------------------------------------------------
// fdom_ctrl
// Sequencer: accept one item, run the mean divider for inserts, then hand
// the result to the output register.
// ----------------------------------------------------------------------------
module fdom_ctrl
	import fdom_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  fdom_stat_t stat,
	output fdom_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DIVIDE = 2'd1;
	localparam logic [1:0] S_LOAD   = 2'd2;

	logic [1:0]           state_q, state_d;
	logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					cnt_d      = '0;
					state_d    = stat.op_insert ? S_DIVIDE : S_LOAD;
				end
			end
			S_DIVIDE: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load_out = stat.out_free;
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

FILE: rtl/core/fdom_dp.sv
// ----------------------------------------------------------------------------
// fdom_dp
// Datapath: circular entry store, head/count/sum registers, result latch,
// iterative mean divider and output register.
// ----------------------------------------------------------------------------
module fdom_dp
	import fdom_pkg::*;
#(
	parameter int CAPACITY = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fdom_cmd_t           cmd,
	output fdom_stat_t          stat,
	input  logic                op,
	input  logic [TAG_W-1:0]    entry_tag,
	input  logic [HEIGHT_W-1:0] height,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [MEAN_W-1:0]   mean_height,
	output logic [TAG_W-1:0]    out_tag,
	output logic [HEIGHT_W-1:0] out_height,
	output logic [FILL_W-1:0]   fill_count
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int ADD_W = IDX_W + 1;
	localparam int SUM_W = HEIGHT_W + CNT_W;
	localparam int NUM_W = SUM_W + 2;
	localparam int REM_W = NUM_W - DIV_BITS;
	localparam int DEN_W = CNT_W + 1;

	// Entry store
	logic [TAG_W-1:0]    tag_mem_q    [CAPACITY];
	logic [HEIGHT_W-1:0] height_mem_q [CAPACITY];

	// Queue bookkeeping
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;

	// Latched result of the accepted item
	logic [STATUS_W-1:0] res_status_q;
	logic [TAG_W-1:0]    res_tag_q;
	logic [HEIGHT_W-1:0] res_height_q;
	logic [FILL_W-1:0]   res_fill_q;

	// Divider
	logic [REM_W-1:0]    rem_q;
	logic [DIV_BITS-1:0] quo_q;
	logic [DEN_W-1:0]    den_q;

	// Output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [MEAN_W-1:0]   out_mean_q;
	logic [TAG_W-1:0]    out_tag_q;
	logic [HEIGHT_W-1:0] out_height_q;
	logic [FILL_W-1:0]   out_fill_q;

	// Combinational update terms
	logic                is_insert;
	logic                full;
	logic                empty;
	logic [IDX_W-1:0]    head_inc;
	logic [ADD_W-1:0]    tail_sum;
	logic [IDX_W-1:0]    tail;
	logic [HEIGHT_W-1:0] head_height;
	logic [TAG_W-1:0]    head_tag;
	logic [IDX_W-1:0]    head_d;
	logic [CNT_W-1:0]    count_d;
	logic [SUM_W-1:0]    sum_d;
	logic [STATUS_W-1:0] status_d;
	logic [NUM_W-1:0]    num;
	logic [REM_W-1:0]    rem_step;
	logic [DIV_BITS-1:0] quo_step;

	assign is_insert   = (op == OP_INSERT);
	assign full        = (count_q == CNT_W'(CAPACITY));
	assign empty       = (count_q == '0);
	assign head_tag    = tag_mem_q[head_q];
	assign head_height = height_mem_q[head_q];
	assign head_inc    = (head_q == IDX_W'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
	assign tail_sum    = {1'b0, head_q} + ADD_W'(count_q);

	// Wrap the tail slot; when full the dropped head slot is reused
	always_comb begin
		if (full) begin
			tail = head_q;
		end else if (tail_sum >= ADD_W'(CAPACITY)) begin
			tail = IDX_W'(tail_sum - ADD_W'(CAPACITY));
		end else begin
			tail = IDX_W'(tail_sum);
		end
	end

	// Next bookkeeping state for the incoming item
	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		sum_d    = sum_q;
		status_d = ST_EMPTY;
		if (is_insert) begin
			if (full) begin
				head_d   = head_inc;
				sum_d    = sum_q - SUM_W'(head_height) + SUM_W'(height);
				status_d = ST_INSERT_DROP;
			end else begin
				count_d  = count_q + 1'b1;
				sum_d    = sum_q + SUM_W'(height);
				status_d = ST_INSERT;
			end
		end else if (!empty) begin
			head_d   = head_inc;
			count_d  = count_q - 1'b1;
			sum_d    = sum_q - SUM_W'(head_height);
			status_d = ST_REMOVE;
		end
	end

	// Rounded mean numerator: 2*sum + n, divided later by 2*n
	assign num = (NUM_W'(sum_d) << 1) + NUM_W'(count_d);

	// Restoring division, DIV_PER_CYC quotient bits per cycle
	always_comb begin
		logic [REM_W:0] trial;
		rem_step = rem_q;
		quo_step = quo_q;
		for (int i = 0; i < DIV_PER_CYC; i++) begin
			trial = {rem_step, quo_step[DIV_BITS-1]};
			if (trial >= (REM_W + 1)'(den_q)) begin
				rem_step = REM_W'(trial - (REM_W + 1)'(den_q));
				quo_step = {quo_step[DIV_BITS-2:0], 1'b1};
			end else begin
				rem_step = REM_W'(trial);
				quo_step = {quo_step[DIV_BITS-2:0], 1'b0};
			end
		end
	end

	// Write the new entry at the tail
	always_ff @(posedge clk) begin
		if (cmd.accept && is_insert) begin
			tag_mem_q[tail]    <= entry_tag;
			height_mem_q[tail] <= height;
		end
	end

	// Advance queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (cmd.accept) begin
			head_q  <= head_d;
			count_q <= count_d;
			sum_q   <= sum_d;
		end
	end

	// Latch the result and seed or step the divider
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_status_q <= status_d;
			res_fill_q   <= FILL_W'(count_d);
			if (!is_insert && !empty) begin
				res_tag_q    <= head_tag;
				res_height_q <= head_height;
			end else begin
				res_tag_q    <= '0;
				res_height_q <= '0;
			end
			den_q <= {count_d, 1'b0};
			if (is_insert) begin
				rem_q <= num[NUM_W-1:DIV_BITS];
				quo_q <= num[DIV_BITS-1:0];
			end else begin
				rem_q <= '0;
				quo_q <= '0;
			end
		end else if (cmd.div_step) begin
			rem_q <= rem_step;
			quo_q <= quo_step;
		end
	end

	// Output register valid: set on load, drop on transfer out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_mean_q   <= quo_q;
			out_tag_q    <= res_tag_q;
			out_height_q <= res_height_q;
			out_fill_q   <= res_fill_q;
		end
	end

	assign stat.op_insert = is_insert;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign mean_height = out_mean_q;
	assign out_tag     = out_tag_q;
	assign out_height  = out_height_q;
	assign fill_count  = out_fill_q;

endmodule

FILE: rtl/core/fifo_drop_oldest_with_mean_top.sv
// ----------------------------------------------------------------------------
// fifo_drop_oldest_with_mean_top
// Bounded FIFO of tag/height entries that drops its oldest entry on a full
// insert and reports the rounded mean height after every insert.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A remove (or a remove on empty) skips the
// divider: the input transfer is followed by the load into the output
// register. An insert runs it: the transfer cycle updates the store and
// running sum, then a restoring divider resolves three bits of the 12-bit
// mean per cycle, then the result is loaded. The output register frees the
// input side: a new item may be accepted while the previous result waits,
// and only the final load waits for out_ready. The mean is
// floor((2*sum + n) / (2*n)), i.e. sum/n rounded half up.
// ----------------------------------------------------------------------------
module fifo_drop_oldest_with_mean_top
	import fdom_pkg::*;
#(
	parameter int CAPACITY = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                op,
	input  logic [TAG_W-1:0]    entry_tag,
	input  logic [HEIGHT_W-1:0] height,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [MEAN_W-1:0]   mean_height,
	output logic [TAG_W-1:0]    out_tag,
	output logic [HEIGHT_W-1:0] out_height,
	output logic [FILL_W-1:0]   fill_count
);

	fdom_cmd_t  cmd;
	fdom_stat_t stat;

	// Sequencer
	fdom_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Store, divider and output register
	fdom_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.op          (op),
		.entry_tag   (entry_tag),
		.height      (height),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.mean_height (mean_height),
		.out_tag     (out_tag),
		.out_height  (out_height),
		.fill_count  (fill_count)
	);

endmodule

FILE: rtl/core/fdom_chk.sv
// ----------------------------------------------------------------------------
// fdom_chk
// Port-level checker for the drop-oldest FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdom_chk
	import fdom_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [STATUS_W-1:0] status,
	input logic [MEAN_W-1:0]   mean_height,
	input logic [TAG_W-1:0]    out_tag,
	input logic [HEIGHT_W-1:0] out_height,
	input logic [FILL_W-1:0]   fill_count
);

	// Hold a stalled result
	`ASSERT_CLKD(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(mean_height) && $stable(out_tag) && $stable(out_height) && $stable(fill_count))

	// One item at a time: ready drops after an input transfer
	`ASSERT_CLKD(a_one_in_flight, clk, arst_n, in_valid && in_ready |=> !in_ready)

	// Remove on empty reports all zero fields
	`ASSERT_RESULT(a_empty_zero, clk, arst_n, out_valid && status == ST_EMPTY |-> mean_height == '0 && out_tag == '0 && out_height == '0 && fill_count == '0)

	// Insert reports no removed entry and a nonzero fill
	`ASSERT_RESULT(a_insert_fields, clk, arst_n, out_valid && (status == ST_INSERT || status == ST_INSERT_DROP) |-> out_tag == '0 && out_height == '0 && fill_count != '0)

	// Remove reports no mean
	`ASSERT_RESULT(a_remove_mean, clk, arst_n, out_valid && status == ST_REMOVE |-> mean_height == '0)

endmodule

bind fifo_drop_oldest_with_mean_top fdom_chk u_fdom_chk (.*);
